// ===== sv/lmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmrc_pkg
// Shared constants, codes and types for the layered multicast receiver
// congestion control block.
// ----------------------------------------------------------------------------
package lmrc_pkg;

    // Layer count and derived widths
    localparam int LAYERS  = 16;
    localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int CNT_W   = $clog2(LAYERS + 1);

    // Field widths fixed by the header and result formats
    localparam int GRP_W   = 8;
    localparam int SEQ_W   = 16;
    localparam int SLOT_W  = 7;
    localparam int DEAF_W  = 8;
    localparam int LCFG_W  = 5;
    localparam int LOST_W  = 32;
    localparam int NOW_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAF_SLOTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LAYERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAYERS   = 2'd2;

    // Register reset values
    localparam logic [DEAF_W-1:0] DEAF_RST  = 8'd10;
    localparam logic [LCFG_W-1:0] START_RST = 5'd1;
    localparam logic [LCFG_W-1:0] MAX_RST   = 5'd16;

    // Half the sequence space: distance at which gap and late meet
    localparam logic [SEQ_W-1:0] HALF_SEQ = 16'h8000;

    // Per-layer phase
    typedef enum logic [1:0] {
        PH_AWAIT   = 2'd1,
        PH_NEW     = 2'd2,
        PH_LATCHED = 2'd3
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    // One received packet header
    typedef struct packed {
        logic [GRP_W-1:0]  group_index;
        logic [SEQ_W-1:0]  seq_number;
        logic [SLOT_W-1:0] slot_index;
        logic              increase_bit;
    } t_hdr;

    // Effective configuration
    typedef struct packed {
        logic [DEAF_W-1:0] deaf_slots;
        logic [CNT_W-1:0]  max_lim;
    } t_cfg;

    // Load of the subscribed layer count from a start_layers write
    typedef struct packed {
        logic             ld;
        logic [CNT_W-1:0] val;
    } t_start_ld;

    // One result transaction
    typedef struct packed {
        t_status           status;
        logic [GRP_W-1:0]  layer_echo;
        logic              entered;
        logic              dropped;
        logic              added;
        logic [NOW_W-1:0]  layers_now;
        logic              congested;
        logic [DEAF_W-1:0] deaf_remaining;
        logic [LOST_W-1:0] lost_total;
        logic [LOST_W-1:0] lost_layer;
    } t_res;

    // Clamp a layer count to 1..LAYERS
    function automatic logic [CNT_W-1:0] limit_layers(input logic [LCFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > LAYERS) begin
            r = CNT_W'(LAYERS);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/lmrc_cfg.sv =====
// ----------------------------------------------------------------------------
// lmrc_cfg
// Configuration registers: deaf period and maximum layer count, with
// clamping of the layer counts to the supported range. A start_layers write
// is passed straight on to the core.
// ----------------------------------------------------------------------------
module lmrc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lmrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmrc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output lmrc_pkg::t_cfg                    o_cfg,
    output lmrc_pkg::t_start_ld               o_start_ld
);

    logic [lmrc_pkg::DEAF_W-1:0] r_deaf_slots;
    logic [lmrc_pkg::LCFG_W-1:0] r_max_layers;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deaf_slots   <= lmrc_pkg::DEAF_RST;
            r_max_layers   <= lmrc_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lmrc_pkg::CFG_DEAF_SLOTS: begin
                    r_deaf_slots <= i_cfg_wdata[lmrc_pkg::DEAF_W-1:0];
                end
                lmrc_pkg::CFG_START_LAYERS: begin
                    // goes straight into the core's layer count
                end
                lmrc_pkg::CFG_MAX_LAYERS: begin
                    r_max_layers <= i_cfg_wdata[lmrc_pkg::LCFG_W-1:0];
                end
                default: begin
                    r_deaf_slots <= r_deaf_slots;
                end
            endcase
        end
    end

    // Effective values; the start count loads the core on the write itself
    assign o_cfg.deaf_slots = r_deaf_slots;
    assign o_cfg.max_lim    = lmrc_pkg::limit_layers(r_max_layers);
    assign o_start_ld.ld    = i_cfg_we && (i_cfg_index == lmrc_pkg::CFG_START_LAYERS);
    assign o_start_ld.val   = lmrc_pkg::limit_layers(i_cfg_wdata[lmrc_pkg::LCFG_W-1:0]);

endmodule

// ===== sv/lmrc_core.sv =====
// ----------------------------------------------------------------------------
// lmrc_core
// Receiver state (per-layer sequence tracking, loss counters, slot and
// deaf period, subscribed layer count) and the single-pass update for one
// header, with the result register.
// ----------------------------------------------------------------------------
module lmrc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  lmrc_pkg::t_hdr        i_hdr,
    input  lmrc_pkg::t_cfg        i_cfg,
    input  lmrc_pkg::t_start_ld   i_start_ld,
    output lmrc_pkg::t_res        o_res
);

    localparam int LAYERS  = lmrc_pkg::LAYERS;
    localparam int LAYER_W = lmrc_pkg::LAYER_W;
    localparam int CNT_W   = lmrc_pkg::CNT_W;
    localparam int SEQ_W   = lmrc_pkg::SEQ_W;
    localparam int SLOT_W  = lmrc_pkg::SLOT_W;
    localparam int DEAF_W  = lmrc_pkg::DEAF_W;
    localparam int LOST_W  = lmrc_pkg::LOST_W;

    // Saturating counter arithmetic
    function automatic logic [LOST_W-1:0] sat_add(input logic [LOST_W-1:0] a,
                                                  input logic [SEQ_W-1:0]  b);
        logic [LOST_W:0] s;
        s = {1'b0, a} + (LOST_W+1)'(b);
        return s[LOST_W] ? '1 : s[LOST_W-1:0];
    endfunction

    function automatic logic [LOST_W-1:0] sat_dec(input logic [LOST_W-1:0] a);
        return (a != '0) ? (a - LOST_W'(1)) : '0;
    endfunction

    // State
    logic                   r_started, n_started;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    lmrc_pkg::t_phase       r_phase [LAYERS];
    lmrc_pkg::t_phase       n_phase [LAYERS];
    logic [SEQ_W-1:0]       r_exp [LAYERS];
    logic [SEQ_W-1:0]       n_exp [LAYERS];
    logic [LAYERS-1:0]      r_inc, n_inc;
    logic [DEAF_W-1:0]      r_deaf, n_deaf;
    logic                   r_cong, n_cong;
    logic [CNT_W-1:0]       r_ls, n_ls;
    logic [LOST_W-1:0]      r_lost_sum, n_lost_sum;
    logic [LOST_W-1:0]      r_lost [LAYERS];
    logic [LOST_W-1:0]      n_lost [LAYERS];
    lmrc_pkg::t_res         r_res, n_res;

    // Working signals
    logic [LAYER_W-1:0]     idx;
    logic [LAYER_W-1:0]     top_idx;
    logic [LAYER_W-1:0]     add_idx;
    logic                   bad;
    logic [SEQ_W-1:0]       exp_g;
    logic [SEQ_W-1:0]       seq_step;
    logic                   gap;
    logic [SLOT_W-1:0]      new_slot;
    logic [DEAF_W-1:0]      deaf_dn;
    logic [CNT_W-1:0]       ls_m1;
    logic                   decided;

    assign idx      = i_hdr.group_index[LAYER_W-1:0];
    assign ls_m1    = r_ls - CNT_W'(1);
    assign top_idx  = ls_m1[LAYER_W-1:0];
    assign add_idx  = r_ls[LAYER_W-1:0];
    assign exp_g    = r_exp[idx];
    assign seq_step = i_hdr.seq_number - exp_g;
    assign gap      = !seq_step[SEQ_W-1]
                      || ((seq_step == lmrc_pkg::HALF_SEQ) && (exp_g > i_hdr.seq_number));
    assign bad      = (32'(i_hdr.group_index) >= 32'(r_ls))
                      || (32'(i_hdr.group_index) >= LAYERS);

    // Header analysis and next state
    always_comb begin
        n_started  = r_started;
        n_slot     = r_slot;
        n_phase    = r_phase;
        n_exp      = r_exp;
        n_inc      = r_inc;
        n_deaf     = r_deaf;
        n_cong     = r_cong;
        n_ls       = r_ls;
        n_lost_sum = r_lost_sum;
        n_lost     = r_lost;
        new_slot   = i_hdr.slot_index;
        deaf_dn    = (r_deaf != '0) ? (r_deaf - DEAF_W'(1)) : '0;
        decided    = 1'b0;
        n_res.status   = lmrc_pkg::ST_OK;
        n_res.entered  = 1'b0;
        n_res.dropped  = 1'b0;
        n_res.added    = 1'b0;

        if (bad) begin
            n_res.status = lmrc_pkg::ST_BAD;
        end else if (!r_started || (r_phase[idx] == lmrc_pkg::PH_AWAIT)) begin
            // First packet of the session or of a freshly joined layer
            if (!r_started) begin
                n_slot    = i_hdr.slot_index;
                n_started = 1'b1;
            end
            n_exp[idx]   = i_hdr.seq_number + SEQ_W'(1);
            n_phase[idx] = lmrc_pkg::PH_LATCHED;
            n_inc[idx]   = i_hdr.increase_bit;
        end else begin
            // Sequence check: in order, gap or late arrival
            if (i_hdr.seq_number == exp_g) begin
                n_exp[idx] = exp_g + SEQ_W'(1);
            end else begin
                if (gap) begin
                    n_lost_sum  = sat_add(r_lost_sum, seq_step);
                    n_lost[idx] = sat_add(r_lost[idx], seq_step);
                    n_exp[idx]  = i_hdr.seq_number + SEQ_W'(1);
                end else begin
                    n_lost_sum  = sat_dec(r_lost_sum);
                    n_lost[idx] = sat_dec(r_lost[idx]);
                    new_slot    = r_slot;
                end
                n_cong = 1'b1;
            end

            // Slot boundary: drop or add decision
            if (new_slot != r_slot) begin
                n_res.entered = 1'b1;
                n_slot        = new_slot;
                n_deaf        = deaf_dn;
                for (int i = 0; i < LAYERS; i++) begin
                    n_phase[i] = lmrc_pkg::PH_NEW;
                end
                if (n_cong) begin
                    if ((deaf_dn == '0) && (r_ls > CNT_W'(1))) begin
                        n_ls              = ls_m1;
                        n_deaf            = i_cfg.deaf_slots;
                        n_phase[top_idx]  = lmrc_pkg::PH_AWAIT;
                        n_res.dropped     = 1'b1;
                    end
                    decided = 1'b1;
                end else if (r_inc[top_idx]) begin
                    if (r_ls < i_cfg.max_lim) begin
                        n_ls             = r_ls + CNT_W'(1);
                        n_phase[add_idx] = lmrc_pkg::PH_AWAIT;
                        n_res.added      = 1'b1;
                    end
                end
                n_cong = 1'b0;
            end

            // Latch or check the increase bit of this layer
            if (!decided) begin
                if (n_phase[idx] == lmrc_pkg::PH_NEW) begin
                    n_inc[idx]   = i_hdr.increase_bit;
                    n_phase[idx] = lmrc_pkg::PH_LATCHED;
                end else if (r_inc[idx] != i_hdr.increase_bit) begin
                    n_res.status = lmrc_pkg::ST_MISMATCH;
                end
            end
        end

        n_res.layer_echo     = i_hdr.group_index;
        n_res.layers_now     = lmrc_pkg::NOW_W'(n_ls);
        n_res.congested      = n_cong;
        n_res.deaf_remaining = n_deaf;
        n_res.lost_total     = n_lost_sum;
        n_res.lost_layer     = bad ? '0 : n_lost[idx];
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_slot     <= '0;
            r_inc      <= '0;
            r_deaf     <= '0;
            r_cong     <= 1'b0;
            r_ls       <= lmrc_pkg::limit_layers(lmrc_pkg::START_RST);
            r_lost_sum <= '0;
            r_res      <= '0;
            for (int i = 0; i < LAYERS; i++) begin
                r_phase[i] <= lmrc_pkg::PH_AWAIT;
                r_exp[i]   <= '0;
                r_lost[i]  <= '0;
            end
        end else if (i_adv) begin
            r_started  <= n_started;
            r_slot     <= n_slot;
            r_phase    <= n_phase;
            r_exp      <= n_exp;
            r_inc      <= n_inc;
            r_deaf     <= n_deaf;
            r_cong     <= n_cong;
            r_ls       <= n_ls;
            r_lost_sum <= n_lost_sum;
            r_lost     <= n_lost;
            r_res      <= n_res;
        end else if (i_start_ld.ld && !r_started) begin
            r_ls <= i_start_ld.val;
        end
    end

    assign o_res = r_res;

    // Checks
    a_ls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ls >= CNT_W'(1)) && (32'(r_ls) <= LAYERS))
        else $error("subscribed layer count out of range");

    a_drop_add_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_res.dropped && r_res.added))
        else $error("layer dropped and added on one packet");

    a_change_on_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.dropped || r_res.added) |-> r_res.entered)
        else $error("layer change outside a slot boundary");

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("session start flag cleared");

    a_drop_restarts_deaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_res.dropped) |=> (r_deaf == $past(i_cfg.deaf_slots)))
        else $error("deaf period not restarted on drop");

endmodule

// ===== sv/layered_multicast_receiver_control_top.sv =====
// ----------------------------------------------------------------------------
// layered_multicast_receiver_control_top
// Receiver congestion control for layered multicast: per-packet header
// analysis, loss counting and layer join/leave decisions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one packet header per
//   transaction: layer number, sequence number, slot index, increase bit.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per header, in order.
//   A header accepted from the input channel sits in the input register; its
//   result is loaded and valid once the result register is free or being taken.
//   Throughput: one header per cycle; the whole update is one pass of logic
//   between the input register and the state and result registers.
//   When the receiver stalls the result register holds; the input register
//   still takes one more header, after which o_in_ready drops until the
//   result is taken.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_wdata) is written while the
//   block is idle. Writes take effect at once; a start_layers write also sets
//   the subscribed layer count until the first valid packet arrives.
//   Reset (i_rst_n, synchronous, active low) clears all per-layer state
//   directly and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module layered_multicast_receiver_control_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration
    input  logic                              i_cfg_we,
    input  logic [lmrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmrc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Header input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lmrc_pkg::GRP_W-1:0]        i_group_index,
    input  logic [lmrc_pkg::SEQ_W-1:0]        i_seq_number,
    input  logic [lmrc_pkg::SLOT_W-1:0]       i_slot_index,
    input  logic                              i_increase_bit,
    // Result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [lmrc_pkg::GRP_W-1:0]        o_layer_echo,
    output logic                              o_entered_new_slot,
    output logic                              o_dropped_layer,
    output logic                              o_added_layer,
    output logic [lmrc_pkg::NOW_W-1:0]        o_layers_now,
    output logic                              o_congested,
    output logic [lmrc_pkg::DEAF_W-1:0]       o_deaf_remaining,
    output logic [lmrc_pkg::LOST_W-1:0]       o_lost_total,
    output logic [lmrc_pkg::LOST_W-1:0]       o_lost_this_layer
);

    logic                  r_in_v;
    logic                  r_out_v;
    lmrc_pkg::t_hdr        r_hdr;
    logic                  adv;
    lmrc_pkg::t_cfg        cfg;
    lmrc_pkg::t_start_ld   start_ld;
    lmrc_pkg::t_res        res;

    // Advance when a header is held and the result slot is free or leaving
    assign adv        = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_hdr.group_index  <= i_group_index;
            r_hdr.seq_number   <= i_seq_number;
            r_hdr.slot_index   <= i_slot_index;
            r_hdr.increase_bit <= i_increase_bit;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    lmrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_start_ld  (start_ld)
    );

    lmrc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_hdr      (r_hdr),
        .i_cfg      (cfg),
        .i_start_ld (start_ld),
        .o_res      (res)
    );

    // Result fields
    assign o_out_valid        = r_out_v;
    assign o_status           = res.status;
    assign o_layer_echo       = res.layer_echo;
    assign o_entered_new_slot = res.entered;
    assign o_dropped_layer    = res.dropped;
    assign o_added_layer      = res.added;
    assign o_layers_now       = res.layers_now;
    assign o_congested        = res.congested;
    assign o_deaf_remaining   = res.deaf_remaining;
    assign o_lost_total       = res.lost_total;
    assign o_lost_this_layer  = res.lost_layer;

endmodule
